// ----- sv/fah_pkg.sv -----
// Package with the field widths and sequencer states of the flip-age history table.
`default_nettype none

package fah_pkg;

    localparam int VAR_W   = 12;
    localparam int STEP_W  = 32;
    localparam int DEPTH_W = 3;
    localparam int AGE_W   = 32;
    localparam int IN_W    = 48;

    typedef enum logic [4:0] {
        ST_CLEAR = 5'b00001,
        ST_IDLE  = 5'b00010,
        ST_META  = 5'b00100,
        ST_RING  = 5'b01000,
        ST_DONE  = 5'b10000
    } state_t;

endpackage

`default_nettype wire

// ----- sv/fah_ram.sv -----
// Generic single-port-write, single-port-read RAM with a registered read.
`default_nettype none

module fah_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 4096,
    localparam int ADDR_W = $clog2(DEPTH)
) (
    input  wire logic              clk,
    input  wire logic              wr_en,
    input  wire logic [ADDR_W-1:0] wr_addr,
    input  wire logic [WIDTH-1:0]  wr_data,
    input  wire logic              rd_en,
    input  wire logic [ADDR_W-1:0] rd_addr,
    output logic      [WIDTH-1:0]  rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

`default_nettype wire

// ----- sv/flip_age_history_table.sv -----
// Top level of the flip-age history table: per-variable last flip step and interval ring.
//
//  Channel  Direction  Signals                        Word
//  s_axis   in         tvalid tready tdata tuser     tuser: mode; tdata: var_index, step, depth
//  m_axis   out        tvalid tready tdata           tdata: age
//
//  A flip is a metadata read, then one write to both memories.
//  A query is a metadata read, then one ring slot read per cycle
//  from the single ring memory port, then the result transfer into the output register.
//  After reset a clearing pass zeroes the metadata memory; no word is
//  accepted during it. The ring memory is never cleared; a per-variable flip count masks
//  slots not yet written.
//  A word is accepted while the previous result still waits in the output register.
`default_nettype none

module flip_age_history_table
    import fah_pkg::*;
#(
    parameter int NUM_VARS    = 4096,
    parameter int HISTORY_LEN = 6
) (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             s_axis_tvalid,
    output logic                  s_axis_tready,
    input  wire logic [IN_W-1:0]  s_axis_tdata,  // var_index[11:0], step[43:12], depth[46:44]
    input  wire logic             s_axis_tuser,  // mode
    output logic                  m_axis_tvalid,
    input  wire logic             m_axis_tready,
    output logic      [AGE_W-1:0] m_axis_tdata   // age[31:0]
);

    localparam int AW = $clog2(NUM_VARS);
    localparam int RING_DEPTH = NUM_VARS * HISTORY_LEN;
    localparam int RW = $clog2(RING_DEPTH);
    localparam int PW = (HISTORY_LEN > 1) ? $clog2(HISTORY_LEN) : 1;
    localparam int CW = $clog2(HISTORY_LEN + 1);

    typedef struct packed {
        logic [CW-1:0]     cnt;
        logic [PW-1:0]     pos;
        logic [STEP_W-1:0] last;
    } meta_t;

    localparam int MW = $bits(meta_t);

    state_t state_reg, state_next;

    logic [AW-1:0]      clr_reg, clr_next;
    logic               out_valid_reg, out_valid_next;
    logic [AGE_W-1:0]   out_age_reg, out_age_next;
    logic               mode_reg, mode_next;
    logic               var_ok_reg, var_ok_next;
    logic [AW-1:0]      var_addr_reg, var_addr_next;
    logic [STEP_W-1:0]  step_reg, step_next;
    logic [DEPTH_W-1:0] depth_reg, depth_next;
    logic [RW-1:0]      base_reg, base_next;
    logic [PW-1:0]      slot_reg, slot_next;
    logic [DEPTH_W-1:0] j_reg, j_next;
    logic [CW-1:0]      cnt_reg, cnt_next;
    logic [AGE_W-1:0]   age_reg, age_next;

    logic               accept;
    logic [VAR_W-1:0]   in_var;
    logic [STEP_W-1:0]  in_step;
    logic [DEPTH_W-1:0] in_depth;
    logic [DEPTH_W-1:0] depth_clamped;
    logic [AW-1:0]      in_addr;

    logic               meta_we;
    logic [AW-1:0]      meta_waddr;
    meta_t              meta_wdata;
    logic [MW-1:0]      meta_rdata;
    meta_t              meta_rd;

    logic               ring_we;
    logic [RW-1:0]      ring_waddr;
    logic [STEP_W-1:0]  ring_wdata;
    logic               ring_re;
    logic [RW-1:0]      ring_raddr;
    logic [STEP_W-1:0]  ring_rdata;

    logic [PW-1:0]      slot_first;
    logic [PW-1:0]      slot_step;
    logic [PW-1:0]      slot_sel;
    logic               flip_wr;
    logic               load_out;

    assign accept        = s_axis_tvalid && s_axis_tready;
    assign s_axis_tready = (state_reg == ST_IDLE);
    assign in_var        = s_axis_tdata[11:0];
    assign in_step       = s_axis_tdata[43:12];
    assign in_depth      = s_axis_tdata[46:44];
    assign in_addr       = AW'(in_var);
    assign depth_clamped = (32'(in_depth) > 32'(HISTORY_LEN)) ? DEPTH_W'(HISTORY_LEN)
                                                              : in_depth;

    assign meta_rd  = meta_t'(meta_rdata);
    assign flip_wr  = (state_reg == ST_META) && !mode_reg && var_ok_reg;
    assign load_out = (state_reg == ST_DONE) && (!out_valid_reg || m_axis_tready);

    assign slot_first = (meta_rd.pos == '0) ? PW'(HISTORY_LEN - 1) : meta_rd.pos - PW'(1);
    assign slot_step  = (slot_reg == '0) ? PW'(HISTORY_LEN - 1) : slot_reg - PW'(1);
    assign slot_sel   = (state_reg == ST_META) ? slot_first : slot_step;

    always_comb
    begin
        meta_we    = 1'b0;
        meta_waddr = var_addr_reg;
        meta_wdata = '0;
        if (state_reg == ST_CLEAR)
        begin
            meta_we    = 1'b1;
            meta_waddr = clr_reg;
        end
        else if (flip_wr)
        begin
            meta_we         = 1'b1;
            meta_wdata.cnt  = (meta_rd.cnt == CW'(HISTORY_LEN)) ? meta_rd.cnt
                                                                : meta_rd.cnt + CW'(1);
            meta_wdata.pos  = (meta_rd.pos == PW'(HISTORY_LEN - 1)) ? '0
                                                                    : meta_rd.pos + PW'(1);
            meta_wdata.last = step_reg;
        end
    end

    assign ring_we    = flip_wr;
    assign ring_waddr = base_reg + RW'(meta_rd.pos);
    assign ring_wdata = step_reg - meta_rd.last;
    assign ring_raddr = base_reg + RW'(slot_sel);
    assign ring_re    = ((state_reg == ST_META) && mode_reg && var_ok_reg
                         && (depth_reg != '0))
                     || ((state_reg == ST_RING) && (j_reg != depth_reg));

    fah_ram #(
        .WIDTH (MW),
        .DEPTH (NUM_VARS)
    ) u_meta_ram (
        .clk     (clk),
        .wr_en   (meta_we),
        .wr_addr (meta_waddr),
        .wr_data (meta_wdata),
        .rd_en   (accept),
        .rd_addr (in_addr),
        .rd_data (meta_rdata)
    );

    fah_ram #(
        .WIDTH (STEP_W),
        .DEPTH (RING_DEPTH)
    ) u_ring_ram (
        .clk     (clk),
        .wr_en   (ring_we),
        .wr_addr (ring_waddr),
        .wr_data (ring_wdata),
        .rd_en   (ring_re),
        .rd_addr (ring_raddr),
        .rd_data (ring_rdata)
    );

    always_comb
    begin
        state_next     = state_reg;
        clr_next       = clr_reg;
        mode_next      = mode_reg;
        var_ok_next    = var_ok_reg;
        var_addr_next  = var_addr_reg;
        step_next      = step_reg;
        depth_next     = depth_reg;
        base_next      = base_reg;
        slot_next      = slot_reg;
        j_next         = j_reg;
        cnt_next       = cnt_reg;
        age_next       = age_reg;
        out_age_next   = out_age_reg;
        out_valid_next = out_valid_reg;

        if (m_axis_tready)
        begin
            out_valid_next = 1'b0;
        end

        unique case (state_reg)
            ST_CLEAR:
            begin
                clr_next = clr_reg + AW'(1);
                if (clr_reg == AW'(NUM_VARS - 1))
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (accept)
                begin
                    mode_next     = s_axis_tuser;
                    var_ok_next   = (32'(in_var) < 32'(NUM_VARS));
                    var_addr_next = in_addr;
                    step_next     = in_step;
                    depth_next    = depth_clamped;
                    base_next     = RW'(in_addr * HISTORY_LEN);
                    state_next    = ST_META;
                end
            end
            ST_META:
            begin
                cnt_next = meta_rd.cnt;
                age_next = var_ok_reg ? step_reg - meta_rd.last : '0;
                if (!mode_reg)
                begin
                    state_next = ST_IDLE;
                end
                else if (!var_ok_reg || (depth_reg == '0))
                begin
                    state_next = ST_DONE;
                end
                else
                begin
                    j_next     = DEPTH_W'(1);
                    slot_next  = slot_first;
                    state_next = ST_RING;
                end
            end
            ST_RING:
            begin
                age_next = age_reg + ((8'(j_reg) <= 8'(cnt_reg)) ? ring_rdata : '0);
                if (j_reg == depth_reg)
                begin
                    state_next = ST_DONE;
                end
                else
                begin
                    j_next    = j_reg + DEPTH_W'(1);
                    slot_next = slot_step;
                end
            end
            ST_DONE:
            begin
                if (load_out)
                begin
                    out_valid_next = 1'b1;
                    out_age_next   = age_reg;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_CLEAR;
            clr_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            clr_reg       <= clr_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        mode_reg     <= mode_next;
        var_ok_reg   <= var_ok_next;
        var_addr_reg <= var_addr_next;
        step_reg     <= step_next;
        depth_reg    <= depth_next;
        base_reg     <= base_next;
        slot_reg     <= slot_next;
        j_reg        <= j_next;
        cnt_reg      <= cnt_next;
        age_reg      <= age_next;
        out_age_reg  <= out_age_next;
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_age_reg;

`ifndef SYNTHESIS
    a_ring_index: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_RING) |-> ((j_reg != '0) && (j_reg <= depth_reg)))
        else $error("ring index out of the requested depth");

    a_no_write_on_accept: assert property (@(posedge clk) disable iff (!rst_n)
        (meta_we || ring_we) |-> !accept)
        else $error("memory write while a word is accepted");

    a_meta_sane: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_META)
        |-> ((32'(meta_rd.pos) < 32'(HISTORY_LEN)) && (32'(meta_rd.cnt) <= 32'(HISTORY_LEN))))
        else $error("metadata entry holds a position or count out of range");

    a_flip_no_result: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && !s_axis_tuser) |=> ##1 (state_reg == ST_IDLE))
        else $error("flip did not complete in two cycles");

    a_load_shows: assert property (@(posedge clk) disable iff (!rst_n)
        load_out |=> (m_axis_tvalid && (m_axis_tdata == $past(age_reg))))
        else $error("result not presented after load");
`endif

endmodule

`default_nettype wire

// ----- bench/fah_test_pkg.sv -----
// Word modes shared by the flip-age history table testbench files.
package fah_test_pkg;

    typedef enum logic {
        WORD_FLIP  = 1'b0,
        WORD_QUERY = 1'b1
    } word_mode_t;

endpackage

// ----- bench/flip_age_history_table_check.sv -----
// Checker for the flip-age history table: tracks flip history, predicts every age and compares.
module flip_age_history_table_check
    import fah_pkg::*, fah_test_pkg::*;
#(
    parameter int NUM_VARS    = 4096,
    parameter int HISTORY_LEN = 6
) (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             s_axis_tvalid,
    input  wire logic             s_axis_tready,
    input  wire logic [IN_W-1:0]  s_axis_tdata,
    input  wire logic             s_axis_tuser,
    input  wire logic             m_axis_tvalid,
    input  wire logic             m_axis_tready,
    input  wire logic [AGE_W-1:0] m_axis_tdata,
    output int                    failures,
    output int                    ages_pending
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct {
        logic [VAR_W-1:0] var_index;
        logic [AGE_W-1:0] age;
    } age_expect_t;

    bit [STEP_W-1:0] last_flip_step [NUM_VARS];
    bit [AGE_W-1:0]  flip_intervals [NUM_VARS][HISTORY_LEN];
    int              write_slot     [NUM_VARS];
    age_expect_t     expected_ages  [$];
    int              mismatch_count = 0;

    task automatic track_word(input logic mode, input logic [IN_W-1:0] word);
        logic [VAR_W-1:0]   idx;
        logic [STEP_W-1:0]  step_now;
        int                 depth;
        age_expect_t        entry;
        idx      = word[VAR_W-1:0];
        step_now = word[VAR_W +: STEP_W];
        depth    = int'(word[VAR_W+STEP_W +: DEPTH_W]);
        if (word_mode_t'(mode) == WORD_FLIP)
        begin
            if (int'(idx) < NUM_VARS)
            begin
                flip_intervals[idx][write_slot[idx]] = step_now - last_flip_step[idx];
                write_slot[idx]     = (write_slot[idx] + 1) % HISTORY_LEN;
                last_flip_step[idx] = step_now;
            end
        end
        else
        begin
            entry.var_index = idx;
            entry.age       = '0;
            if (int'(idx) < NUM_VARS)
            begin
                if (depth > HISTORY_LEN)
                    depth = HISTORY_LEN;
                entry.age = step_now - last_flip_step[idx];
                for (int j = 1; j <= depth; j++)
                    entry.age += flip_intervals[idx][(write_slot[idx] + HISTORY_LEN - j)
                                                     % HISTORY_LEN];
            end
            expected_ages.push_back(entry);
        end
    endtask

    task automatic check_age(input logic [AGE_W-1:0] got);
        age_expect_t entry;
        if (expected_ages.size() == 0)
        begin
            if (mismatch_count < 10)
                $display("%0t: unexpected age word %h with no query pending", $realtime, got);
            mismatch_count++;
        end
        else
        begin
            entry = expected_ages.pop_front();
            if (got !== entry.age)
            begin
                if (mismatch_count < 10)
                    $display("%0t: age of variable %0d expected %h, got %h",
                             $realtime, entry.var_index, entry.age, got);
                mismatch_count++;
            end
        end
    endtask

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (s_axis_tvalid && s_axis_tready)
                track_word(s_axis_tuser, s_axis_tdata);
            if (m_axis_tvalid && m_axis_tready)
                check_age(m_axis_tdata);
        end
        failures     <= mismatch_count;
        ages_pending <= expected_ages.size();
    end

endmodule

// ----- bench/flip_age_history_table_test.sv -----
// Testbench top for the flip-age history table: drives flips and age queries, gives the verdict.
module flip_age_history_table_test
    import fah_pkg::*, fah_test_pkg::*;
;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int NUM_VARS        = 4096;
    localparam int HISTORY_LEN     = 6;
    localparam int RANDOM_WORDS    = 1230;
    localparam int HOLD_OFF_AFTER  = 300;
    localparam int HOLD_OFF_CYCLES = 600;
    localparam int DRAIN_CYCLES    = 30;

    logic             clk           = 1'b0;
    logic             rst_n         = 1'b0;
    logic             s_axis_tvalid = 1'b0;
    logic             s_axis_tready;
    logic [IN_W-1:0]  s_axis_tdata  = '0;
    logic             s_axis_tuser  = 1'b0;
    logic             m_axis_tvalid;
    logic             m_axis_tready = 1'b0;
    logic [AGE_W-1:0] m_axis_tdata;

    int failures;
    int ages_pending;
    int words_sent    = 0;
    bit calm_phase    = 1'b0;
    bit hold_off_done = 1'b0;

    always #5 clk = ~clk;

    flip_age_history_table #(
        .NUM_VARS    (NUM_VARS),
        .HISTORY_LEN (HISTORY_LEN)
    ) DUT (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    flip_age_history_table_check #(
        .NUM_VARS    (NUM_VARS),
        .HISTORY_LEN (HISTORY_LEN)
    ) age_check (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .failures      (failures),
        .ages_pending  (ages_pending)
    );

    function automatic int idle_cycles();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        if (r < 93)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    task automatic send_word(input word_mode_t mode, input logic [VAR_W-1:0] idx,
                             input logic [STEP_W-1:0] step_now,
                             input logic [DEPTH_W-1:0] depth);
        int gap;
        s_axis_tuser  <= mode;
        s_axis_tdata  <= {1'b0, depth, step_now, idx};
        s_axis_tvalid <= 1'b1;
        do
            @(posedge clk);
        while (!s_axis_tready);
        words_sent++;
        gap = calm_phase ? 0 : idle_cycles();
        if (gap > 0)
        begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    initial
    begin : result_sink
        int r;
        int len;
        wait (rst_n);
        @(posedge clk);
        forever
        begin
            if (!hold_off_done && words_sent >= HOLD_OFF_AFTER)
            begin
                // The sender keeps offering words, so the block fills up and stalls.
                hold_off_done = 1'b1;
                m_axis_tready <= 1'b0;
                len = HOLD_OFF_CYCLES;
            end
            else
            begin
                r = $urandom_range(0, 99);
                if (calm_phase || r < 60)
                begin
                    m_axis_tready <= 1'b1;
                    len = $urandom_range(1, 30);
                end
                else if (r < 93)
                begin
                    m_axis_tready <= 1'b0;
                    len = $urandom_range(1, 3);
                end
                else
                begin
                    m_axis_tready <= 1'b0;
                    len = $urandom_range(8, 40);
                end
            end
            repeat (len) @(posedge clk);
        end
    end

    initial
    begin : stimulus
        logic [VAR_W-1:0]   hot_vars [8];
        logic [VAR_W-1:0]   idx;
        logic [STEP_W-1:0]  cur_step;
        logic [STEP_W-1:0]  step_now;
        logic [DEPTH_W-1:0] depth;
        word_mode_t         mode;
        int                 r;

        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Never flipped, all-ones step, and a step that goes backward.
        send_word(WORD_QUERY, 12'd0, 32'd0, 3'd0);
        send_word(WORD_QUERY, 12'd4095, 32'hFFFF_FFFF, 3'd6);
        send_word(WORD_FLIP, 12'd4095, 32'd100, 3'd0);
        send_word(WORD_FLIP, 12'd4095, 32'd40, 3'd0);
        send_word(WORD_QUERY, 12'd4095, 32'd50, 3'd7);
        // Seven flips wrap the ring of one variable, then queries at every depth class.
        for (int k = 1; k <= 7; k++)
            send_word(WORD_FLIP, 12'd1, 32'(k * 1000 + k * k), 3'd0);
        send_word(WORD_QUERY, 12'd1, 32'd9000, 3'd0);
        send_word(WORD_QUERY, 12'd1, 32'd9000, 3'd1);
        send_word(WORD_QUERY, 12'd1, 32'd9000, 3'd3);
        send_word(WORD_QUERY, 12'd1, 32'd9000, 3'd6);
        send_word(WORD_QUERY, 12'd1, 32'd9000, 3'd7);
        // Age that wraps past the top of the step range.
        send_word(WORD_FLIP, 12'd0, 32'hFFFF_FFF0, 3'd0);
        send_word(WORD_QUERY, 12'd0, 32'd5, 3'd1);
        send_word(WORD_FLIP, 12'hAAA, 32'h5555_5555, 3'd0);
        send_word(WORD_QUERY, 12'hAAA, 32'hAAAA_AAAA, 3'd5);
        send_word(WORD_QUERY, 12'h555, 32'h5555_5555, 3'd2);

        hot_vars[0] = 12'd0;
        hot_vars[1] = 12'd4095;
        for (int k = 2; k < 8; k++)
            hot_vars[k] = 12'($urandom_range(0, 4095));
        cur_step = $urandom;

        for (int n = 0; n < RANDOM_WORDS; n++)
        begin
            calm_phase = (n >= 700 && n < 800);
            idx = ($urandom_range(0, 99) < 75) ? hot_vars[$urandom_range(0, 7)]
                                               : 12'($urandom_range(0, 4095));
            r = $urandom_range(0, 99);
            if (r < 85)
                cur_step += 32'($urandom_range(0, 500));
            else if (r < 95)
                cur_step += $urandom;
            step_now = (r < 95) ? cur_step : $urandom;
            depth = ($urandom_range(0, 9) == 0) ? 3'd7 : 3'($urandom_range(0, 6));
            mode  = ($urandom_range(0, 99) < 45) ? WORD_FLIP : WORD_QUERY;
            send_word(mode, idx, step_now, depth);
        end
        calm_phase = 1'b0;

        s_axis_tvalid <= 1'b0;
        @(posedge clk);
        while (ages_pending != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (failures == 0)
            $display("[flip_age_history_table] OK");
        else
            $display("[flip_age_history_table] ERROR");
        $finish;
    end

    initial
    begin : watchdog
        #5_000_000;
        $display("[flip_age_history_table] ERROR");
        $finish;
    end

endmodule

// ----- flip_age_history_table.f -----
sv/fah_pkg.sv
sv/fah_ram.sv
sv/flip_age_history_table.sv
bench/fah_test_pkg.sv
bench/flip_age_history_table_check.sv
bench/flip_age_history_table_test.sv
